// ===== rtl/core/wamt_pkg.sv =====
// Package for the weekly alarm match table: table sizes, entry layout and operation codes.
// It has no dependencies and is imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package wamt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int IN_DATA_W   = 88;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 32;

    typedef enum logic [1:0] {
        OP_CHECK   = 2'd0,
        OP_CONFIRM = 2'd1,
        OP_APPEND  = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [6:0]  day_mask;
        logic [15:0] amount;
        logic        enabled;
    } entry_attr_t;

    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [2:0]  weekday;
        logic [31:0] date;
    } now_t;

endpackage
`default_nettype wire

// ===== rtl/core/wamt_match.sv =====
// Due test for one alarm entry against the current time, weekday and date.
// It depends on wamt_pkg for the entry and time layouts.
`timescale 1ns / 1ps
`default_nettype none
module wamt_match (
    input  wire wamt_pkg::entry_attr_t entry,
    input  wire logic [31:0]           last_date,
    input  wire wamt_pkg::now_t        now,
    output logic                       due
);
    import wamt_pkg::*;

    logic [7:0] mask_ext;
    logic       day_hit;

    // Weekday seven selects the padding bit, so it never matches.
    assign mask_ext = {1'b0, entry.day_mask};
    assign day_hit  = mask_ext[now.weekday];

    assign due = entry.enabled
              && (entry.hour == now.hour)
              && (entry.minute == now.minute)
              && day_hit
              && (last_date != now.date);

endmodule
`default_nettype wire

// ===== rtl/core/weekly_alarm_match_table_top.sv =====
// Top level of the weekly alarm match table: sequencer, entry memories and result register.
// It depends on wamt_pkg and instantiates wamt_match as the shared compare unit.
// A check scans at most TABLE_DEPTH entries, one per cycle through the single compare unit, and
// stops at the first due entry; confirm, append and clear go from the execute state straight
// to the result state. One item is in work at a time, and the next is accepted only after
// the result is registered and the sequencer is back in idle. Reset
// clears the entry count and the pending match; the entry memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module weekly_alarm_match_table_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // now_hour[4:0], now_minute[10:5], now_weekday[13:11], now_date[45:14],
    // new_hour[50:46], new_minute[56:51], new_day_mask[63:57], new_amount[79:64],
    // new_enabled[80], zero padding[87:81]
    input  wire logic [wamt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // opcode[1:0]
    input  wire logic [wamt_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // hit[0], hit_index[4:1], hit_amount[20:5], entries_used[25:21], refused[26],
    // zero padding[31:27]
    output logic [wamt_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import wamt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RESULT
    } state_t;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    now_t              now_reg, now_next;
    entry_attr_t       new_reg, new_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic              res_hit_reg, res_hit_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic [15:0]       res_amt_reg, res_amt_next;
    logic              res_ref_reg, res_ref_next;
    logic              m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    entry_attr_t       attr_mem [TABLE_DEPTH];
    logic [31:0]       date_mem [TABLE_DEPTH];
    entry_attr_t       rd_attr_reg;
    logic [31:0]       rd_date_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic              wr_attr_en;
    logic              wr_date_en;
    logic [31:0]       wr_date;
    logic              issuing;
    logic              due;

    wamt_match u_match (
        .entry     (rd_attr_reg),
        .last_date (rd_date_reg),
        .now       (now_reg),
        .due       (due)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign issuing       = (scan_cnt_reg < count_reg);
    assign rd_addr       = scan_cnt_reg[IDX_W-1:0];

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        now_next        = now_reg;
        new_next        = new_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        scan_cnt_next   = scan_cnt_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        res_hit_next    = res_hit_reg;
        res_idx_next    = res_idx_reg;
        res_amt_next    = res_amt_reg;
        res_ref_next    = res_ref_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_data_next     = m_data_reg;
        wr_attr_en      = 1'b0;
        wr_date_en      = 1'b0;
        wr_addr         = count_reg[IDX_W-1:0];
        wr_date         = 32'd0;

        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    op_next           = op_t'(s_axis_tuser[1:0]);
                    now_next.hour     = s_axis_tdata[4:0];
                    now_next.minute   = s_axis_tdata[10:5];
                    now_next.weekday  = s_axis_tdata[13:11];
                    now_next.date     = s_axis_tdata[45:14];
                    new_next.hour     = s_axis_tdata[50:46];
                    new_next.minute   = s_axis_tdata[56:51];
                    new_next.day_mask = s_axis_tdata[63:57];
                    new_next.amount   = s_axis_tdata[79:64];
                    new_next.enabled  = s_axis_tdata[80];
                    state_next        = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_hit_next = 1'b0;
                res_idx_next = '0;
                res_amt_next = 16'd0;
                res_ref_next = 1'b0;
                state_next   = ST_RESULT;
                case (op_reg)
                    OP_CHECK: begin
                        scan_cnt_next = '0;
                        state_next    = ST_SCAN;
                    end
                    OP_CONFIRM: begin
                        if (pend_valid_reg && ({1'b0, pend_idx_reg} < count_reg)) begin
                            wr_date_en      = 1'b1;
                            wr_addr         = pend_idx_reg;
                            wr_date         = now_reg.date;
                            pend_valid_next = 1'b0;
                            pend_idx_next   = '0;
                        end else begin
                            res_ref_next = 1'b1;
                        end
                    end
                    OP_APPEND: begin
                        if (count_reg >= CNT_W'(TABLE_DEPTH)) begin
                            res_ref_next = 1'b1;
                        end else begin
                            wr_attr_en = 1'b1;
                            wr_date_en = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    OP_CLEAR: begin
                        count_next = '0;
                    end
                    default: begin
                        res_ref_next = 1'b0;
                    end
                endcase
            end
            ST_SCAN: begin
                cmp_valid_next = issuing;
                cmp_idx_next   = scan_cnt_reg[IDX_W-1:0];
                if (issuing) begin
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
                if (cmp_valid_reg && due) begin
                    res_hit_next    = 1'b1;
                    res_idx_next    = cmp_idx_reg;
                    res_amt_next    = rd_attr_reg.amount;
                    pend_valid_next = 1'b1;
                    pend_idx_next   = cmp_idx_reg;
                    state_next      = ST_RESULT;
                end else if (!issuing) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'd0, res_ref_reg, count_reg, res_amt_reg,
                                    res_idx_reg, res_hit_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
            cmp_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            pend_idx_reg   <= pend_idx_next;
            cmp_valid_reg  <= cmp_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        op_reg       <= op_next;
        now_reg      <= now_next;
        new_reg      <= new_next;
        scan_cnt_reg <= scan_cnt_next;
        cmp_idx_reg  <= cmp_idx_next;
        res_hit_reg  <= res_hit_next;
        res_idx_reg  <= res_idx_next;
        res_amt_reg  <= res_amt_next;
        res_ref_reg  <= res_ref_next;
        m_data_reg   <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_attr_en) begin
            attr_mem[wr_addr] <= new_reg;
        end
        if (wr_date_en) begin
            date_mem[wr_addr] <= wr_date;
        end
        rd_attr_reg <= attr_mem[rd_addr];
        rd_date_reg <= date_mem[rd_addr];
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(pend_valid_reg) |-> $past(state_reg == ST_EXEC && op_reg == OP_CONFIRM))
        else $error("pending match dropped outside a confirm");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[0]) |-> ({1'b0, m_data_reg[4:1]} < m_data_reg[25:21]))
        else $error("reported hit index is not below the entry count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(pend_valid_reg) |-> $past(state_reg == ST_SCAN && cmp_valid_reg))
        else $error("pending match set without a compared entry");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for weekly_alarm_match_table_top: a queued driver and a monitor
// compare every result item with a local model of the alarm table and its pending match.
// It depends on wamt_pkg and the RTL of the block, and on nothing else.
`timescale 1ns / 1ps
module testbench;
    import wamt_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_ITEMS = 1000;
    localparam int CALM_TAIL = 100;
    localparam int LONG_HOLD = 300;

    typedef struct {
        op_t         op;
        logic [4:0]  now_hour;
        logic [5:0]  now_minute;
        logic [2:0]  now_weekday;
        logic [31:0] now_date;
        logic [4:0]  new_hour;
        logic [5:0]  new_minute;
        logic [6:0]  new_day_mask;
        logic [15:0] new_amount;
        logic        new_enabled;
        bit          drain_first;
    } alarm_cmd_t;

    typedef struct {
        logic             hit;
        logic [3:0]       hit_index;
        logic [15:0]      hit_amount;
        logic [4:0]       entries_used;
        logic             refused;
    } alarm_reply_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Local copy of the alarm table.
    logic [4:0]     tbl_hour[TABLE_DEPTH];
    logic [5:0]     tbl_minute[TABLE_DEPTH];
    logic [6:0]     tbl_days[TABLE_DEPTH];
    logic [15:0]    tbl_grams[TABLE_DEPTH];
    logic           tbl_on[TABLE_DEPTH];
    logic [31:0]    tbl_last[TABLE_DEPTH];
    int unsigned    alarm_count = 0;
    bit             armed = 1'b0;
    int unsigned    armed_index = 0;

    alarm_cmd_t     cmd_q[$];
    alarm_reply_t   reply_q[$];
    alarm_cmd_t     cur_cmd;
    int             sent_count = 0;
    int             got_count = 0;
    int             total_items = 0;
    int             mismatch_count = 0;
    int             send_gap = 0;
    int             recv_hold = 0;
    bit             long_hold_done = 1'b0;
    int             cycle_count = 0;

    weekly_alarm_match_table_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic alarm_reply_t apply_alarm_cmd(alarm_cmd_t c);
        alarm_reply_t r;
        logic [7:0]   days;
        r = '{hit: 1'b0, hit_index: 4'd0, hit_amount: 16'd0, entries_used: 5'd0,
              refused: 1'b0};
        case (c.op)
            OP_CHECK: begin
                for (int i = 0; i < alarm_count; i++) begin
                    days = {1'b0, tbl_days[i]};
                    if (tbl_on[i] && tbl_hour[i] == c.now_hour && tbl_minute[i] == c.now_minute
                        && days[c.now_weekday] && tbl_last[i] != c.now_date) begin
                        r.hit = 1'b1;
                        r.hit_index = 4'(i);
                        r.hit_amount = tbl_grams[i];
                        armed = 1'b1;
                        armed_index = i;
                        break;
                    end
                end
            end
            OP_CONFIRM: begin
                if (armed && armed_index < alarm_count) begin
                    tbl_last[armed_index] = c.now_date;
                    armed = 1'b0;
                    armed_index = 0;
                end else begin
                    r.refused = 1'b1;
                end
            end
            OP_APPEND: begin
                if (alarm_count >= TABLE_DEPTH) begin
                    r.refused = 1'b1;
                end else begin
                    tbl_hour[alarm_count] = c.new_hour;
                    tbl_minute[alarm_count] = c.new_minute;
                    tbl_days[alarm_count] = c.new_day_mask;
                    tbl_grams[alarm_count] = c.new_amount;
                    tbl_on[alarm_count] = c.new_enabled;
                    tbl_last[alarm_count] = 32'd0;
                    alarm_count++;
                end
            end
            default: begin
                alarm_count = 0;
            end
        endcase
        r.entries_used = 5'(alarm_count);
        return r;
    endfunction

    function automatic alarm_cmd_t random_cmd(op_t op);
        alarm_cmd_t c;
        c.op = op;
        c.now_hour = 5'($urandom_range(0, 31));
        c.now_minute = 6'($urandom_range(0, 63));
        c.now_weekday = 3'($urandom_range(0, 7));
        c.now_date = $urandom();
        c.new_hour = 5'($urandom_range(0, 31));
        c.new_minute = 6'($urandom_range(0, 63));
        c.new_day_mask = 7'($urandom_range(0, 127));
        c.new_amount = 16'($urandom_range(0, 65535));
        c.new_enabled = 1'($urandom_range(0, 1));
        c.drain_first = 1'b0;
        return c;
    endfunction

    function automatic alarm_cmd_t timed_cmd(op_t op, int hr, int mn, int wd, int date);
        alarm_cmd_t c;
        c = random_cmd(op);
        c.now_hour = 5'(hr);
        c.now_minute = 6'(mn);
        c.now_weekday = 3'(wd);
        c.now_date = 32'(date);
        return c;
    endfunction

    function automatic alarm_cmd_t entry_cmd(int hr, int mn, int mask, int grams, int en);
        alarm_cmd_t c;
        c = random_cmd(OP_APPEND);
        c.new_hour = 5'(hr);
        c.new_minute = 6'(mn);
        c.new_day_mask = 7'(mask);
        c.new_amount = 16'(grams);
        c.new_enabled = 1'(en);
        return c;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                reply_q.push_back(apply_alarm_cmd(cur_cmd));
                sent_count++;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (cmd_q.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (cmd_q[0].drain_first && reply_q.size() != 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (cmd_q.size() > CALM_TAIL && (sent_count / 100) % 4 != 3
                             && $urandom_range(0, 4) == 0) begin
                    send_gap = $urandom_range(1, 11) - 1;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    cur_cmd = cmd_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= cur_cmd.op;
                    s_axis_tdata <= {7'd0, cur_cmd.new_enabled, cur_cmd.new_amount,
                                     cur_cmd.new_day_mask, cur_cmd.new_minute,
                                     cur_cmd.new_hour, cur_cmd.now_date,
                                     cur_cmd.now_weekday, cur_cmd.now_minute,
                                     cur_cmd.now_hour};
                end
            end
        end
    end

    always @(posedge aclk) begin
        alarm_reply_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_count++;
                if (reply_q.size() == 0) begin
                    $error("result item with no expectation: tdata %h", m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = reply_q.pop_front();
                    if (m_axis_tdata[0] !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, m_axis_tdata[0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[4:1] !== want.hit_index) begin
                        $error("hit_index: expected %0d, got %0d", want.hit_index,
                               m_axis_tdata[4:1]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[20:5] !== want.hit_amount) begin
                        $error("hit_amount: expected %0d, got %0d", want.hit_amount,
                               m_axis_tdata[20:5]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[25:21] !== want.entries_used) begin
                        $error("entries_used: expected %0d, got %0d", want.entries_used,
                               m_axis_tdata[25:21]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[26] !== want.refused) begin
                        $error("refused: expected %0d, got %0d", want.refused,
                               m_axis_tdata[26]);
                        mismatch_count++;
                    end
                end
            end
            if (!long_hold_done && got_count == 400) begin
                long_hold_done = 1'b1;
                recv_hold = LONG_HOLD;
                m_axis_tready <= 1'b0;
            end else if (recv_hold > 0) begin
                recv_hold--;
                m_axis_tready <= 1'b0;
            end else if (got_count < total_items - CALM_TAIL && (got_count / 100) % 4 != 1
                         && $urandom_range(0, 4) == 0) begin
                recv_hold = $urandom_range(1, 11) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        alarm_cmd_t c;
        int         sel;
        int         day;

        // Table empty, nothing pending, then entries at the field extremes.
        cmd_q.push_back(timed_cmd(OP_CHECK, 8, 30, 3, 5));
        cmd_q.push_back(timed_cmd(OP_CONFIRM, 8, 30, 3, 5));
        cmd_q.push_back(entry_cmd(31, 63, 127, 65535, 1));
        cmd_q.push_back(entry_cmd(0, 0, 0, 0, 1));
        cmd_q.push_back(entry_cmd(8, 30, 127, 0, 0));
        cmd_q.push_back(entry_cmd(8, 30, 8, 100, 1));
        cmd_q.push_back(timed_cmd(OP_CHECK, 8, 30, 3, 5));
        cmd_q.push_back(timed_cmd(OP_CONFIRM, 0, 0, 0, 5));
        cmd_q.push_back(timed_cmd(OP_CHECK, 8, 30, 3, 5));
        cmd_q.push_back(timed_cmd(OP_CHECK, 8, 30, 3, 6));
        cmd_q.push_back(timed_cmd(OP_CHECK, 8, 30, 7, 7));
        cmd_q.push_back(timed_cmd(OP_CHECK, 31, 63, 6, 32'hFFFF_FFFF));
        cmd_q.push_back(timed_cmd(OP_CHECK, 0, 0, 0, 1));
        cmd_q.push_back(timed_cmd(OP_CLEAR, 0, 0, 0, 0));
        // The pending index now points past the end of the table.
        cmd_q.push_back(timed_cmd(OP_CONFIRM, 0, 0, 0, 9));
        cmd_q.push_back(entry_cmd(1, 1, 1, 7, 1));
        cmd_q.push_back(timed_cmd(OP_CONFIRM, 0, 0, 0, 0));
        cmd_q.push_back(timed_cmd(OP_CHECK, 1, 1, 0, 0));
        cmd_q.push_back(timed_cmd(OP_CHECK, 1, 1, 0, 1));
        c = timed_cmd(OP_CONFIRM, 0, 0, 0, 1);
        c.drain_first = 1'b1;
        cmd_q.push_back(c);

        day = 1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sel = $urandom_range(0, 99);
            c = random_cmd(OP_CHECK);
            if (sel < 35) c.op = OP_APPEND;
            else if (sel < 37) c.op = OP_CLEAR;
            else if (sel < 57) c.op = OP_CONFIRM;
            if ($urandom_range(0, 9) != 0) begin
                c.now_hour = 5'(6 + $urandom_range(0, 2));
                c.now_minute = 6'(15 * $urandom_range(0, 2));
                c.now_weekday = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                            : 3'(day % 7);
                c.now_date = 32'(day);
                c.new_hour = 5'(6 + $urandom_range(0, 2));
                c.new_minute = 6'(15 * $urandom_range(0, 2));
                if ($urandom_range(0, 2) == 0) c.new_day_mask = 7'h7F;
                c.new_enabled = ($urandom_range(0, 4) != 0);
            end
            if ($urandom_range(0, 9) == 0) day++;
            if ($urandom_range(0, 60) == 0) c.drain_first = 1'b1;
            cmd_q.push_back(c);
        end
        total_items = cmd_q.size();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmd_q.size() != 0 || s_axis_tvalid) @(posedge aclk);
        while (reply_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
